### rtl/life_cellular_automaton_unit_defines.svh
// assertion macros for the life cellular automaton unit checker
// expects signals named clock and reset in the scope where a macro is used

`ifndef LIFE_CELLULAR_AUTOMATON_UNIT_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LCA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lca checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define LCA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lca checker: next-cycle property failed");

`endif

### rtl/lca_pkg.sv
// shared types and constants for the life cellular automaton unit
// no dependencies; imported by lca_row_update, life_cellular_automaton_unit, lca_checker and the testbench

package lca_pkg;

   // grid bounds
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   // derived widths
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WSIZE_W = $clog2(MAX_WIDTH + 1);
   localparam int HSIZE_W = $clog2(MAX_HEIGHT + 1);
   localparam int IDX_W   = $clog2(MAX_HEIGHT + 2);
   localparam int PCNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int AREA_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   // fixed field widths
   localparam int SIZE_REG_W = 7;
   localparam int GEN_W      = 8;
   localparam int DEAD_W     = 13;
   localparam int DATA_W     = 32;
   localparam int REG_IDX_W  = 2;
   localparam int ADDR_W     = REG_IDX_W + 2;

   localparam logic [DEAD_W-1:0] DEAD_MAX = '1;

   // register reset values
   localparam logic [SIZE_REG_W-1:0] WIDTH_RESET   = 7'd64;
   localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET  = 7'd64;
   localparam logic [GEN_W-1:0]      MAX_GEN_RESET = 8'd100;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_GEN = 2'd2;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;

   // b3/s23 rule thresholds
   localparam logic [3:0] SURVIVE_NBRS = 4'd2;
   localparam logic [3:0] BIRTH_NBRS   = 4'd3;

   typedef logic [MAX_WIDTH-1:0] row_type;

   // three neighboring rows around the row being updated
   typedef struct packed {
      row_type above;
      row_type middle;
      row_type below;
   } row_window_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] row;
      logic [5:0] column;
      logic       alive_in;
   } req_item_type;

   typedef struct packed {
      logic              alive_out;
      logic [GEN_W-1:0]  generations_done;
      logic [DEAD_W-1:0] dead_count;
      logic              all_dead;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_COUNT,
      ST_GEN,
      ST_DRAIN,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

### rtl/lca_ram.sv
// generic simple dual-port ram with registered read
// no dependencies

module lca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lca_row_update.sv
// next-generation logic for one grid row under the b3/s23 rule
// depends on lca_pkg for row types and rule thresholds

module lca_row_update
   import lca_pkg::*;
(
   input  row_window_type window,
   input  row_type        col_mask,
   output row_type        next_row
);

   // neighbors outside the used columns count as dead; pad both ends with zero
   logic [MAX_WIDTH+1:0] above_ext;
   logic [MAX_WIDTH+1:0] middle_ext;
   logic [MAX_WIDTH+1:0] below_ext;

   assign above_ext  = {1'b0, window.above & col_mask, 1'b0};
   assign middle_ext = {1'b0, window.middle & col_mask, 1'b0};
   assign below_ext  = {1'b0, window.below & col_mask, 1'b0};

   // one cell per column, columns beyond the used width keep their bit
   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
      logic [3:0] nbr;
      logic       life;

      assign nbr = 4'(above_ext[c]) + 4'(above_ext[c+1]) + 4'(above_ext[c+2])
                 + 4'(middle_ext[c]) + 4'(middle_ext[c+2])
                 + 4'(below_ext[c]) + 4'(below_ext[c+1]) + 4'(below_ext[c+2]);

      assign life = middle_ext[c+1] ? ((nbr == SURVIVE_NBRS) || (nbr == BIRTH_NBRS))
                                    : (nbr == BIRTH_NBRS);

      assign next_row[c] = col_mask[c] ? life : window.middle[c];
   end

endmodule

### rtl/life_cellular_automaton_unit.sv
// life cellular automaton unit: write, read and run items on a row-wide grid
// write/read: fetch the row, set or read the cell, count the used rows; run and unused code:
// count the rows, then a pass per run generation. the row-serial grid ram walk sets the rate:
// one row per cycle through the shared row update and popcount units.
// one item at a time; the next is accepted the cycle after the result is taken.
// synchronous reset: grid reads as all dead, registers take their defaults.

module life_cellular_automaton_unit
   import lca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_item_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   state_type               state_ff, state_in;
   logic [SIZE_REG_W-1:0]   width_ff, width_in;
   logic [SIZE_REG_W-1:0]   height_ff, height_in;
   logic [GEN_W-1:0]        max_gen_ff, max_gen_in;
   req_item_type            item_ff, item_in;
   logic [GEN_W-1:0]        gen_ff, gen_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [MAX_HEIGHT-1:0]   valid_ff, valid_in;
   row_type                 prev_ff, prev_in;
   row_type                 cur_ff, cur_in;
   row_type                 cnt_row_ff, cnt_row_in;
   logic [AREA_W-1:0]       live_ff, live_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic                    read_bit_ff, read_bit_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;

   logic [WSIZE_W-1:0]      used_w;
   logic [HSIZE_W-1:0]      used_h;
   row_type                 col_mask;
   logic [AREA_W-1:0]       area;
   logic [AREA_W-1:0]       dead_full;
   logic [PCNT_W-1:0]       pcnt;
   logic [REG_IDX_W-1:0]    reg_idx;
   logic                    cfg_write;
   logic                    req_accept;
   logic                    in_area;
   logic                    data_row_ok;
   logic                    count_last;
   logic                    gen_last;
   logic                    gen_write;
   logic                    run_more;
   logic                    live_clear;
   logic [IDX_W-1:0]        wr_idx;
   logic [COL_W-1:0]        col_sel;
   row_type                 rd_data;
   row_type                 rd_row;
   row_type                 in_row;
   row_type                 new_row;
   row_type                 mod_row;
   row_window_type          window;
   logic [ROW_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [ROW_W-1:0]        wr_addr;
   row_type                 wr_data;

   // configuration port
   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_WIDTH:   prdata = DATA_W'(width_ff);
         REG_HEIGHT:  prdata = DATA_W'(height_ff);
         REG_MAX_GEN: prdata = DATA_W'(max_gen_ff);
         default:     prdata = '0;
      endcase
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      max_gen_in = max_gen_ff;
      if (cfg_write) begin
         case (reg_idx)
            REG_WIDTH:   width_in   = pwdata[SIZE_REG_W-1:0];
            REG_HEIGHT:  height_in  = pwdata[SIZE_REG_W-1:0];
            REG_MAX_GEN: max_gen_in = pwdata[GEN_W-1:0];
            default:     ;
         endcase
      end
   end

   // used grid size, zero taken as one, saturated at the grid bounds
   always_comb begin
      if (width_ff == '0) begin
         used_w = WSIZE_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         used_w = WSIZE_W'(MAX_WIDTH);
      end else begin
         used_w = WSIZE_W'(width_ff);
      end
      if (height_ff == '0) begin
         used_h = HSIZE_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         used_h = HSIZE_W'(MAX_HEIGHT);
      end else begin
         used_h = HSIZE_W'(height_ff);
      end
   end

   always_comb begin
      for (int c = 0; c < MAX_WIDTH; c++) begin
         col_mask[c] = (c < int'(used_w));
      end
   end

   assign area = AREA_W'(used_w) * AREA_W'(used_h);

   // sequencing conditions
   assign req_accept  = req_valid && !req_stall;
   assign in_area     = (int'(item_ff.row) < int'(used_h))
                     && (int'(item_ff.column) < int'(used_w));
   assign data_row_ok = (idx_ff != '0) && (int'(idx_ff) <= int'(used_h));
   assign count_last  = (int'(idx_ff) == int'(used_h));
   assign gen_last    = (int'(idx_ff) == int'(used_h) + 1);
   assign gen_write   = (int'(idx_ff) >= 2);
   assign wr_idx      = idx_ff - IDX_W'(2);
   assign run_more    = (item_ff.operation == OP_RUN) && (gen_ff < max_gen_ff)
                     && (live_ff != '0);
   assign live_clear  = (state_ff == ST_IDLE) || (state_ff == ST_FETCH)
                     || (state_ff == ST_MODIFY) || (state_ff == ST_CHECK)
                     || (state_ff == ST_DONE);

   // grid rows; a row never written since reset reads as all dead
   lca_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_row = rd_vld_ff ? rd_data : '0;
   assign in_row = data_row_ok ? rd_row : '0;

   // single-cell write merged into the fetched row
   assign col_sel = COL_W'(item_ff.column);
   always_comb begin
      mod_row          = rd_row;
      mod_row[col_sel] = item_ff.alive_in;
   end

   // sliding three-row window feeding the shared row update
   assign window.above  = prev_ff;
   assign window.middle = cur_ff;
   assign window.below  = in_row;

   lca_row_update u_row_update (
      .window   (window),
      .col_mask (col_mask),
      .next_row (new_row)
   );

   // shared live-cell counter
   assign pcnt      = PCNT_W'($countones(cnt_row_ff));
   assign dead_full = area - live_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if ((req_item.operation == OP_WRITE) || (req_item.operation == OP_READ)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_FETCH:  state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_COUNT;
         ST_COUNT: begin
            if (count_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_GEN: begin
            if (gen_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_CHECK;
         ST_CHECK: state_in = run_more ? ST_GEN : ST_DONE;
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake, ram port and counter feed
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_DONE);
      rd_addr    = idx_ff[ROW_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = wr_idx[ROW_W-1:0];
      wr_data    = new_row;
      cnt_row_in = '0;
      case (state_ff)
         ST_FETCH: rd_addr = ROW_W'(item_ff.row);
         ST_MODIFY: begin
            wr_en   = in_area && (item_ff.operation == OP_WRITE);
            wr_addr = ROW_W'(item_ff.row);
            wr_data = mod_row;
         end
         ST_COUNT: cnt_row_in = in_row & col_mask;
         ST_GEN: begin
            wr_en      = gen_write;
            cnt_row_in = gen_write ? (new_row & col_mask) : '0;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      item_in     = item_ff;
      gen_in      = gen_ff;
      read_bit_in = read_bit_ff;
      rsp_item_in = rsp_item_ff;
      idx_in      = ((state_ff == ST_COUNT) || (state_ff == ST_GEN)) ? idx_ff + IDX_W'(1) : '0;
      rd_vld_in   = valid_ff[rd_addr];
      live_in     = live_clear ? '0 : live_ff + AREA_W'(pcnt);
      prev_in     = '0;
      cur_in      = '0;
      valid_in    = valid_ff;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (state_ff == ST_GEN) begin
         prev_in = cur_ff;
         cur_in  = in_row;
      end

      // new item
      if (req_accept) begin
         item_in     = req_item;
         gen_in      = '0;
         read_bit_in = 1'b0;
      end

      // single-cell read
      if ((state_ff == ST_MODIFY) && (item_ff.operation == OP_READ)) begin
         read_bit_in = in_area && rd_row[col_sel];
      end

      // generation finished
      if ((state_ff == ST_GEN) && gen_last) begin
         gen_in = gen_ff + GEN_W'(1);
      end

      // build the result
      if (state_ff == ST_CHECK) begin
         rsp_item_in.alive_out        = read_bit_ff;
         rsp_item_in.generations_done = gen_ff;
         rsp_item_in.dead_count       = (int'(dead_full) > int'(DEAD_MAX))
                                      ? DEAD_MAX : DEAD_W'(dead_full);
         rsp_item_in.all_dead         = (live_ff == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         max_gen_ff <= MAX_GEN_RESET;
         valid_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         max_gen_ff <= max_gen_in;
         valid_ff   <= valid_in;
         idx_ff     <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      gen_ff      <= gen_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      cnt_row_ff  <= cnt_row_in;
      live_ff     <= live_in;
      rd_vld_ff   <= rd_vld_in;
      read_bit_ff <= read_bit_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_item = rsp_item_ff;

endmodule

### rtl/lca_checker.sv
// port-level checker for the life cellular automaton unit, bound to the top level
// depends on lca_pkg and life_cellular_automaton_unit_defines.svh

`include "life_cellular_automaton_unit_defines.svh"

module lca_checker
   import lca_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rsp_item_type      rsp_item
);

   // one item at a time: busy right after an accept
   `LCA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // no new item while a result waits
   `LCA_ASSERT_NOW(a_stall_while_pending, rsp_valid, req_stall)

   // a stalled result holds
   `LCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // an all-dead grid cannot read a live cell and has a nonzero dead count
   `LCA_ASSERT_NOW(a_dead_grid_consistent, rsp_valid && rsp_item.all_dead,
                   !rsp_item.alive_out && (rsp_item.dead_count != '0))

endmodule

bind life_cellular_automaton_unit lca_checker u_lca_checker (.*);

### sim/life_cellular_automaton_unit_test.sv
// testbench for the life cellular automaton unit: write, read, run and unused-code items
// checked against an in-bench b3/s23 grid predictor, plus register reads; needs lca_pkg and the unit

module life_cellular_automaton_unit_test;
   import lca_pkg::*;

   localparam logic [1:0]           OP_UNUSED       = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPARE       = 2'd3;
   localparam int                   WATCHDOG_LIMIT  = 40000;
   localparam int                   RANDOM_OPS      = 480;
   localparam int                   REPORT_LIMIT    = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_item_type      req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_item_type      rsp_item;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // predictor copy of the grid and the registers
   logic [MAX_WIDTH-1:0]  life_cells [MAX_HEIGHT];
   logic [SIZE_REG_W-1:0] width_reg   = WIDTH_RESET;
   logic [SIZE_REG_W-1:0] height_reg  = HEIGHT_RESET;
   logic [GEN_W-1:0]      max_gen_reg = MAX_GEN_RESET;

   req_item_type cell_ops_pending [$];
   rsp_item_type expected_cell_results [$];
   int           ops_queued = 0;
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           stall_run = 0;
   int           free_run = 0;

   life_cellular_automaton_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #10 clock = ~clock;

   initial begin
      for (int r = 0; r < MAX_HEIGHT; r++) life_cells[r] = '0;
   end

   function automatic int used_extent(logic [SIZE_REG_W-1:0] reg_val, int limit);
      if (reg_val == 0) return 1;
      if (reg_val > limit) return limit;
      return int'(reg_val);
   endfunction

   function automatic int count_dead_cells(int w, int h);
      int dead;
      dead = 0;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            if (!life_cells[r][c]) dead++;
      return dead;
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // apply one item to the predicted grid and return its result
   function automatic rsp_item_type step_life_grid(req_item_type op_item);
      int                   w, h, dead, nbrs, rr, cc;
      logic [GEN_W-1:0]     gens;
      logic [MAX_WIDTH-1:0] next_cells [MAX_HEIGHT];
      rsp_item_type         res;
      w = used_extent(width_reg, MAX_WIDTH);
      h = used_extent(height_reg, MAX_HEIGHT);
      res = '0;
      case (op_item.operation)
         OP_WRITE: begin
            if (op_item.row < h && op_item.column < w)
               life_cells[op_item.row][op_item.column] = op_item.alive_in;
         end
         OP_READ: begin
            if (op_item.row < h && op_item.column < w)
               res.alive_out = life_cells[op_item.row][op_item.column];
         end
         OP_RUN: begin
            gens = '0;
            while (gens < max_gen_reg && count_dead_cells(w, h) < w * h) begin
               for (int r = 0; r < h; r++) begin
                  for (int c = 0; c < w; c++) begin
                     nbrs = 0;
                     for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                           rr = r + dr;
                           cc = c + dc;
                           if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h
                               && cc < w) begin
                              if (life_cells[rr][cc]) nbrs++;
                           end
                        end
                     end
                     // birth on three, survival on two or three
                     if (life_cells[r][c])
                        next_cells[r][c] = (nbrs == SURVIVE_NBRS || nbrs == BIRTH_NBRS);
                     else
                        next_cells[r][c] = (nbrs == BIRTH_NBRS);
                  end
               end
               for (int r = 0; r < h; r++)
                  for (int c = 0; c < w; c++)
                     life_cells[r][c] = next_cells[r][c];
               gens++;
            end
            res.generations_done = gens;
         end
         default: ;
      endcase
      dead = count_dead_cells(w, h);
      res.dead_count = (dead > DEAD_MAX) ? DEAD_MAX : dead[DEAD_W-1:0];
      res.all_dead = (dead == w * h);
      return res;
   endfunction

   // item sender: bursts of items with random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_cell_results.push_back(step_life_grid(req_item));
            void'(cell_ops_pending.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cell_ops_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_item <= cell_ops_pending[0];
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result checker, receiver stall pattern and watchdog
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cell_results.size() == 0) begin
               report_mismatch($sformatf("result with none expected: %p", rsp_item));
            end else begin
               want = expected_cell_results.pop_front();
               if (rsp_item.alive_out !== want.alive_out
                   || rsp_item.generations_done !== want.generations_done
                   || rsp_item.dead_count !== want.dead_count
                   || rsp_item.all_dead !== want.all_dead)
                  report_mismatch($sformatf("expected %p got %p", want, rsp_item));
            end
         end
         // stall stretches mixed with long quiet windows
         if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if (free_run > 0) begin
            free_run--;
            rsp_stall <= 1'b0;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               free_run = $urandom_range(50, 300);
            end else begin
               free_run = $urandom_range(0, 8);
               stall_run = $urandom_range(1, 20);
            end
            rsp_stall <= 1'b0;
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_op(logic [1:0] op, int row, int col, logic alive);
      req_item_type op_item;
      op_item.operation = op;
      op_item.row = row[5:0];
      op_item.column = col[5:0];
      op_item.alive_in = alive;
      cell_ops_pending.push_back(op_item);
      ops_queued++;
   endtask

   task automatic write_csr(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_WIDTH:   width_reg = value[SIZE_REG_W-1:0];
         REG_HEIGHT:  height_reg = value[SIZE_REG_W-1:0];
         REG_MAX_GEN: max_gen_reg = value[GEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_csr(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== want)
         report_mismatch($sformatf("register %0d read %h, expected %h", idx, prdata, want));
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // random upper bits go along to show they are dropped
   task automatic configure_grid(int w_raw, int h_raw, int gen_raw);
      logic [DATA_W-1:0] value;
      value = $urandom();
      value[SIZE_REG_W-1:0] = w_raw[SIZE_REG_W-1:0];
      write_csr(REG_WIDTH, value);
      value = $urandom();
      value[SIZE_REG_W-1:0] = h_raw[SIZE_REG_W-1:0];
      write_csr(REG_HEIGHT, value);
      value = $urandom();
      value[GEN_W-1:0] = gen_raw[GEN_W-1:0];
      write_csr(REG_MAX_GEN, value);
   endtask

   task automatic check_all_csrs();
      check_csr(REG_WIDTH, DATA_W'(width_reg));
      check_csr(REG_HEIGHT, DATA_W'(height_reg));
      check_csr(REG_MAX_GEN, DATA_W'(max_gen_reg));
   endtask

   task automatic wait_for_idle();
      do @(negedge clock);
      while (cell_ops_pending.size() != 0 || expected_cell_results.size() != 0 || req_valid);
      repeat (4) @(negedge clock);
   endtask

   function automatic int pick_size();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 0;
      if (sel == 1) return $urandom_range(65, 127);
      if (sel == 2) return 64;
      if (sel <= 4) return $urandom_range(13, 40);
      return $urandom_range(1, 12);
   endfunction

   initial begin
      int w, h, w_raw, h_raw, gen_raw, n_fill, n_ops, kind, span_r, span_c, r0, c0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset registers: empty grid, corners, a blinker and the unused code
      queue_op(OP_READ, 0, 0, 1'b0);
      queue_op(OP_RUN, 0, 0, 1'b0);
      queue_op(OP_WRITE, 0, 0, 1'b1);
      queue_op(OP_WRITE, 63, 63, 1'b1);
      queue_op(OP_WRITE, 0, 63, 1'b1);
      queue_op(OP_READ, 63, 63, 1'b0);
      queue_op(OP_UNUSED, 63, 63, 1'b1);
      queue_op(OP_WRITE, 11, 20, 1'b1);
      queue_op(OP_WRITE, 11, 21, 1'b1);
      queue_op(OP_WRITE, 11, 22, 1'b1);
      queue_op(OP_RUN, 0, 0, 1'b0);
      queue_op(OP_READ, 11, 21, 1'b0);
      queue_op(OP_WRITE, 0, 0, 1'b0);
      wait_for_idle();

      // small area with zero generations, cells outside left alone
      configure_grid(8, 8, 0);
      check_all_csrs();
      queue_op(OP_WRITE, 2, 2, 1'b1);
      queue_op(OP_RUN, 0, 0, 1'b0);
      queue_op(OP_READ, 11, 21, 1'b0);
      queue_op(OP_WRITE, 11, 21, 1'b0);
      wait_for_idle();

      // zero sizes mean one cell; spare register index is ignored
      configure_grid(0, 0, 255);
      write_csr(REG_SPARE, $urandom());
      check_all_csrs();
      queue_op(OP_WRITE, 0, 0, 1'b1);
      queue_op(OP_RUN, 0, 0, 1'b0);
      queue_op(OP_READ, 0, 1, 1'b0);
      wait_for_idle();

      // oversized registers saturate at the full grid
      configure_grid(127, 100, 2);
      check_all_csrs();
      queue_op(OP_READ, 11, 21, 1'b0);
      queue_op(OP_RUN, 0, 0, 1'b0);
      queue_op(OP_READ, 63, 63, 1'b0);
      wait_for_idle();

      // random phases: clustered seed pattern, then a mix of items
      ops_queued = 0;
      while (ops_queued < RANDOM_OPS) begin
         w_raw = pick_size();
         h_raw = pick_size();
         case ($urandom_range(0, 9))
            0:       gen_raw = 0;
            1:       gen_raw = 255;
            2:       gen_raw = 1;
            default: gen_raw = $urandom_range(2, 40);
         endcase
         // tall areas are slow per generation, keep their runs short
         if (used_extent(h_raw[SIZE_REG_W-1:0], MAX_HEIGHT) > 16 && gen_raw > 12)
            gen_raw = $urandom_range(0, 12);
         configure_grid(w_raw, h_raw, gen_raw);
         if ($urandom_range(0, 2) == 0) check_all_csrs();
         if ($urandom_range(0, 4) == 0) write_csr(REG_SPARE, $urandom());
         w = used_extent(width_reg, MAX_WIDTH);
         h = used_extent(height_reg, MAX_HEIGHT);
         span_r = (h < 6) ? h : 6;
         span_c = (w < 6) ? w : 6;
         r0 = $urandom_range(0, h - span_r);
         c0 = $urandom_range(0, w - span_c);
         n_fill = $urandom_range(0, span_r * span_c);
         for (int i = 0; i < n_fill; i++)
            queue_op(OP_WRITE, r0 + $urandom_range(0, span_r - 1),
                     c0 + $urandom_range(0, span_c - 1), $urandom_range(0, 9) < 6);
         n_ops = $urandom_range(8, 24);
         for (int i = 0; i < n_ops; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               if ($urandom_range(0, 6) == 0)
                  queue_op(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                           1'($urandom_range(0, 1)));
               else
                  queue_op(OP_WRITE, r0 + $urandom_range(0, span_r - 1),
                           c0 + $urandom_range(0, span_c - 1), 1'($urandom_range(0, 1)));
            end else if (kind < 65) begin
               if ($urandom_range(0, 4) == 0)
                  queue_op(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                           1'($urandom_range(0, 1)));
               else
                  queue_op(OP_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                           1'($urandom_range(0, 1)));
            end else if (kind < 92) begin
               queue_op(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
            end else begin
               queue_op(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
            end
         end
         wait_for_idle();
      end

      // settle once idle, then judge
      repeat (80) @(posedge clock);
      if (expected_cell_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_cell_results.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
